>>> rtl/positional_array_insert_delete_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional array insert/delete block
// Shared property forms: same-cycle and next-cycle implication on clk_i.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PAID_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PAID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/paid_pkg.sv
// ---------------------------------------------------------------------------
// paid_pkg
// Types, sizes and codes shared by the positional array insert/delete block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package paid_pkg;

  localparam int DEPTH   = 128;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FUNC_W  = 2;
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int ECNT_W  = 8;
  localparam int STAT_W  = 2;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOP,
    S_SHIFT_WR,
    S_READ_WAIT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture a new command and check it
    logic rd_shift;  // read the neighbor entry that moves next
    logic wr_shift;  // write the moved entry and step the index
    logic rd_pos;    // read the entry at the command position
    logic put;       // write the new word and bump the count
    logic drop;      // lower the count after a delete
    logic respond;   // register the result fields
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    op_e  op;
    logic ok;
    logic more;      // entries remain to be shifted
  } dp_status_t;

endpackage

>>> rtl/positional_array_insert_delete.sv
// ---------------------------------------------------------------------------
// positional_array_insert_delete
// Ordered store of signed words with append, insert, delete and read.
// ---------------------------------------------------------------------------
// Usage: raise start_i with func_i, position_i and value_i; the command is
// taken at the edge where start_i is high and busy_o is low. Exactly one
// result comes back per command, shown on read_value_o, element_count_o and
// status_o for the single cycle in which done_o is high; the receiver cannot
// stall it, so sample it then. A full store or a bad position returns a
// status code and leaves the store and the count unchanged. Insert and
// delete run a shift loop that moves count minus position entries for
// insert and count minus position minus one for delete; each moved entry
// is first read from the element store and then written back to it at its
// new index. No clearing pass follows reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_array_insert_delete_defines.svh"

module positional_array_insert_delete (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [paid_pkg::FUNC_W-1:0]          func_i,
  input  logic [paid_pkg::POS_W-1:0]           position_i,
  input  logic signed [paid_pkg::WORD_W-1:0]   value_i,
  output logic                                 done_o,
  output logic signed [paid_pkg::WORD_W-1:0]   read_value_o,
  output logic [paid_pkg::ECNT_W-1:0]          element_count_o,
  output logic [paid_pkg::STAT_W-1:0]          status_o
);
  import paid_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  // Sequence each command: check, shift, finish, then post one transfer.
  paid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd),
    .busy_o      (busy_o),
    .done_o      (done_o)
  );

  // Hold the store, the count and the result registers.
  paid_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .dp_status_o     (dp_status),
    .read_value_o    (read_value_o),
    .element_count_o (element_count_o),
    .status_o        (status_o)
  );

  // An accepted command keeps the block busy in the next cycle.
  `PAID_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accept did not raise busy")
  // A result transfer never repeats in back-to-back cycles.
  `PAID_ASSERT_NEXT(a_single_done, done_o, !done_o, "result strobe held two cycles")
  // A failed command returns no read data.
  `PAID_ASSERT_SAME(a_fail_zero, done_o && status_o != STAT_OK, read_value_o == '0, "read data on error")
  // A write and a read never go to the store in the same cycle.
  `PAID_ASSERT_SAME(a_one_mem_op, cmd.wr_shift || cmd.put, !cmd.rd_shift && !cmd.rd_pos, "port conflict")

endmodule

>>> rtl/paid_ctrl.sv
// ---------------------------------------------------------------------------
// paid_ctrl
// Sequencer for one command at a time: check, shift loop, finish, respond.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module paid_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  paid_pkg::dp_status_t   dp_status_i,
  output paid_pkg::cmd_t         cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import paid_pkg::*;

  state_e state_q, state_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.respond;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!dp_status_i.ok) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end else begin
          unique case (dp_status_i.op)
            OP_APPEND: begin
              cmd_o.put     = 1'b1;
              cmd_o.respond = 1'b1;
              state_d       = S_IDLE;
            end
            OP_READ: begin
              cmd_o.rd_pos = 1'b1;
              state_d      = S_READ_WAIT;
            end
            default: state_d = S_LOOP;
          endcase
        end
      end
      S_LOOP: begin
        if (dp_status_i.more) begin
          cmd_o.rd_shift = 1'b1;
          state_d        = S_SHIFT_WR;
        end else begin
          // finish: place the word or shrink the count
          cmd_o.put     = (dp_status_i.op == OP_INSERT);
          cmd_o.drop    = (dp_status_i.op == OP_DELETE);
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_LOOP;
      end
      S_READ_WAIT: begin
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

>>> rtl/paid_datapath.sv
// ---------------------------------------------------------------------------
// paid_datapath
// Element store, count, shift index, command checks and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module paid_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  paid_pkg::cmd_t                       cmd_i,
  input  logic [paid_pkg::FUNC_W-1:0]          func_i,
  input  logic [paid_pkg::POS_W-1:0]           position_i,
  input  logic signed [paid_pkg::WORD_W-1:0]   value_i,
  output paid_pkg::dp_status_t                 dp_status_o,
  output logic signed [paid_pkg::WORD_W-1:0]   read_value_o,
  output logic [paid_pkg::ECNT_W-1:0]          element_count_o,
  output logic [paid_pkg::STAT_W-1:0]          status_o
);
  import paid_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q;
  logic [CMP_W-1:0]  pos_q;
  logic [WORD_W-1:0] val_q;
  op_e               op_q;
  status_e           stat_q, stat_d;
  logic [WORD_W-1:0] rdata_q;

  logic [WORD_W-1:0] rval_q;
  logic [ECNT_W-1:0] ecnt_q;
  status_e           rstat_q;

  op_e               op_in;
  logic [CMP_W-1:0]  pos_in;
  logic [CMP_W-1:0]  cnt_cmp;
  logic              full;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data;

  assign op_in   = op_e'(func_i);
  assign pos_in  = CMP_W'(position_i);
  assign cnt_cmp = CMP_W'(count_q);
  assign full    = (count_q == CNT_W'(DEPTH));

  // Check a new command against the current count.
  always_comb begin
    stat_d = STAT_OK;
    unique case (op_in)
      OP_APPEND: if (full) stat_d = STAT_FULL;
      OP_INSERT: begin
        if (full)                  stat_d = STAT_FULL;
        else if (pos_in > cnt_cmp) stat_d = STAT_BADPOS;
      end
      default:   if (pos_in >= cnt_cmp) stat_d = STAT_BADPOS;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.put)  count_d = count_q + CNT_W'(1);
    if (cmd_i.drop) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Latch the command; insert walks down from the end, delete walks up.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_in;
      pos_q  <= pos_in;
      val_q  <= value_i;
      stat_q <= stat_d;
      idx_q  <= (op_in == OP_INSERT) ? count_q : CNT_W'(position_i);
    end else if (cmd_i.wr_shift) begin
      idx_q  <= (op_q == OP_INSERT) ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
    end
  end

  // Memory port addressing.
  assign mem_re  = cmd_i.rd_shift | cmd_i.rd_pos;
  assign mem_we  = cmd_i.wr_shift | cmd_i.put;
  assign wr_data = cmd_i.put ? val_q : rdata_q;

  always_comb begin
    if (cmd_i.rd_pos)
      rd_addr = pos_q[IDX_W-1:0];
    else if (op_q == OP_INSERT)
      rd_addr = idx_q[IDX_W-1:0] - IDX_W'(1);
    else
      rd_addr = idx_q[IDX_W-1:0] + IDX_W'(1);
  end

  always_comb begin
    if (cmd_i.wr_shift)
      wr_addr = idx_q[IDX_W-1:0];
    else if (op_q == OP_APPEND)
      wr_addr = count_q[IDX_W-1:0];
    else
      wr_addr = pos_q[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rdata_q <= mem[rd_addr];
  end

  // Result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      rval_q  <= (op_q == OP_READ && stat_q == STAT_OK) ? rdata_q : '0;
      ecnt_q  <= ECNT_W'(count_d);
      rstat_q <= stat_q;
    end
  end

  assign dp_status_o.op   = op_q;
  assign dp_status_o.ok   = (stat_q == STAT_OK);
  assign dp_status_o.more = (op_q == OP_INSERT) ? (CMP_W'(idx_q) > pos_q)
                                                : ((CMP_W'(idx_q) + CMP_W'(1)) < cnt_cmp);

  assign read_value_o    = signed'(rval_q);
  assign element_count_o = ecnt_q;
  assign status_o        = rstat_q;

endmodule
